// File: design/bwq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwq_pkg
// Shared constants and types of the block weight quantiser: lane count,
// configuration register indexes, mode codes and the configuration bundle.
// ----------------------------------------------------------------------------
package bwq_pkg;

    // Weights per block
    localparam int LANES       = 8;
    localparam int LANE_IDX_W  = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int MODE_W      = 2;
    localparam int LIMIT_W     = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_E8_LIMIT   = 1'b1;

    // Quantisation modes; the unused code behaves as E8
    localparam logic [MODE_W-1:0] MODE_E8   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INT8 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INT4 = 2'd3;

    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_E8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd15;

    // Result code width and integer clamp levels
    localparam int CODE_W   = 8;
    localparam int INT8_LIM = 127;
    localparam int INT4_LIM = 7;

    // E8 scale 7.25 written as 29 / 4
    localparam int E8_NUM = 29;

    // Lattice coordinate width (covers +-9 after the parity fix)
    localparam int ZW = 5;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

endpackage
`default_nettype wire

// File: design/bwq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwq_if
// Streaming channels of the block weight quantiser: the weight block going in
// and the scale plus codes coming out, each with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface bwq_weights_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] weight_0;
    logic signed [WEIGHT_BITS-1:0] weight_1;
    logic signed [WEIGHT_BITS-1:0] weight_2;
    logic signed [WEIGHT_BITS-1:0] weight_3;
    logic signed [WEIGHT_BITS-1:0] weight_4;
    logic signed [WEIGHT_BITS-1:0] weight_5;
    logic signed [WEIGHT_BITS-1:0] weight_6;
    logic signed [WEIGHT_BITS-1:0] weight_7;

    modport source (
        output valid, weight_0, weight_1, weight_2, weight_3,
               weight_4, weight_5, weight_6, weight_7,
        input  ready
    );
    modport sink (
        input  valid, weight_0, weight_1, weight_2, weight_3,
               weight_4, weight_5, weight_6, weight_7,
        output ready
    );
endinterface

interface bwq_result_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [WEIGHT_BITS-1:0] block_max;
    logic signed [7:0]      code_0;
    logic signed [7:0]      code_1;
    logic signed [7:0]      code_2;
    logic signed [7:0]      code_3;
    logic signed [7:0]      code_4;
    logic signed [7:0]      code_5;
    logic signed [7:0]      code_6;
    logic signed [7:0]      code_7;

    modport source (
        output valid, block_max, code_0, code_1, code_2, code_3,
               code_4, code_5, code_6, code_7,
        input  ready
    );
    modport sink (
        input  valid, block_max, code_0, code_1, code_2, code_3,
               code_4, code_5, code_6, code_7,
        output ready
    );
endinterface
`default_nettype wire

// File: design/bwq_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwq_scale
// Front end: magnitudes, block maximum over two stages, then the dividend
// and divisor of the per-weight scaling for the selected mode.
// ----------------------------------------------------------------------------
module bwq_scale
    import bwq_pkg::*;
#(
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 8,
    localparam int NW = WEIGHT_BITS + FRACTION_BITS + 4,
    localparam int DW = WEIGHT_BITS + 2
)
(
    input  logic                          clk,
    input  logic [2:0]                    en,
    input  cfg_t                          cfg,
    input  logic signed [WEIGHT_BITS-1:0] weight [LANES],
    output logic [NW-1:0]                 num    [LANES],
    output logic [DW-1:0]                 den,
    output logic [LANES-1:0]              neg,
    output logic [WEIGHT_BITS-1:0]        blk_max
);

    localparam logic [NW-1:0] E8_MULT   = NW'(E8_NUM) << FRACTION_BITS;
    localparam logic [NW-1:0] INT8_MULT = NW'(2 * INT8_LIM);
    localparam logic [NW-1:0] INT4_MULT = NW'(2 * INT4_LIM);

    logic [WEIGHT_BITS-1:0] mag_next  [LANES];
    logic [WEIGHT_BITS-1:0] pmax_next [LANES/2];
    logic [WEIGHT_BITS-1:0] max_next;
    logic [NW-1:0]          num_next  [LANES];
    logic [DW-1:0]          den_next;
    logic                   int_mode;

    logic [WEIGHT_BITS-1:0] mag0_reg  [LANES];
    logic [WEIGHT_BITS-1:0] pmax0_reg [LANES/2];
    logic [LANES-1:0]       neg0_reg;
    logic [WEIGHT_BITS-1:0] mag1_reg  [LANES];
    logic [WEIGHT_BITS-1:0] max1_reg;
    logic [LANES-1:0]       neg1_reg;
    logic [NW-1:0]          num_reg   [LANES];
    logic [DW-1:0]          den_reg;
    logic [LANES-1:0]       neg2_reg;
    logic [WEIGHT_BITS-1:0] max2_reg;

    // Magnitudes and pairwise maxima
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag_next[i] = weight[i][WEIGHT_BITS-1] ? $unsigned(-weight[i])
                                                   : $unsigned(weight[i]);
        end
        for (int p = 0; p < LANES/2; p++)
        begin
            pmax_next[p] = (mag_next[2*p] >= mag_next[2*p+1]) ? mag_next[2*p]
                                                              : mag_next[2*p+1];
        end
    end

    // Finish the maximum over the four pair maxima
    always_comb
    begin
        logic [WEIGHT_BITS-1:0] m01;
        logic [WEIGHT_BITS-1:0] m23;
        m01 = (pmax0_reg[0] >= pmax0_reg[1]) ? pmax0_reg[0] : pmax0_reg[1];
        m23 = (pmax0_reg[2] >= pmax0_reg[3]) ? pmax0_reg[2] : pmax0_reg[3];
        max_next = (m01 >= m23) ? m01 : m23;
    end

    // Dividend and divisor: rounding half away folded into the dividend
    assign int_mode = (cfg.mode == MODE_INT8) || (cfg.mode == MODE_INT4);

    always_comb
    begin
        logic [NW-1:0] lim2;
        lim2 = (cfg.mode == MODE_INT8) ? INT8_MULT : INT4_MULT;
        for (int i = 0; i < LANES; i++)
        begin
            if (int_mode)
            begin
                num_next[i] = NW'(mag1_reg[i]) * lim2 + NW'(max1_reg);
            end
            else
            begin
                num_next[i] = NW'(mag1_reg[i]) * E8_MULT + (NW'(max1_reg) << 1);
            end
        end
        den_next = int_mode ? (DW'(max1_reg) << 1) : (DW'(max1_reg) << 2);
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag0_reg  <= mag_next;
            pmax0_reg <= pmax_next;
            for (int i = 0; i < LANES; i++)
            begin
                neg0_reg[i] <= weight[i][WEIGHT_BITS-1];
            end
        end
        if (en[1])
        begin
            mag1_reg <= mag0_reg;
            max1_reg <= max_next;
            neg1_reg <= neg0_reg;
        end
        if (en[2])
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            neg2_reg <= neg1_reg;
            max2_reg <= max1_reg;
        end
    end

    assign num     = num_reg;
    assign den     = den_reg;
    assign neg     = neg2_reg;
    assign blk_max = max2_reg;

endmodule
`default_nettype wire

// File: design/bwq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwq_div
// Pipelined restoring divider, eight lanes sharing one divisor; two quotient
// bits are resolved per stage, most significant first.
// ----------------------------------------------------------------------------
module bwq_div
    import bwq_pkg::*;
#(
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 8,
    localparam int NW   = WEIGHT_BITS + FRACTION_BITS + 4,
    localparam int DW   = WEIGHT_BITS + 2,
    localparam int QB   = FRACTION_BITS + 3,
    localparam int NDIV = (QB + 1) / 2
)
(
    input  logic                   clk,
    input  logic [NDIV-1:0]        en,
    input  logic [NW-1:0]          num     [LANES],
    input  logic [DW-1:0]          den,
    input  logic [LANES-1:0]       neg,
    input  logic [WEIGHT_BITS-1:0] blk_max,
    output logic [QB-1:0]          quo     [LANES],
    output logic [LANES-1:0]       quo_neg,
    output logic [WEIGHT_BITS-1:0] quo_max
);

    // The last stage keeps no remainder and no divisor
    logic [NW-1:0]          rem_reg [NDIV-1][LANES];
    logic [DW-1:0]          den_reg [NDIV-1];
    logic [QB-1:0]          q_reg   [NDIV][LANES];
    logic [LANES-1:0]       neg_reg [NDIV];
    logic [WEIGHT_BITS-1:0] max_reg [NDIV];

    for (genvar k = 0; k < NDIV; k++)
    begin : g_stage
        logic [NW-1:0]          rem_in  [LANES];
        logic [QB-1:0]          q_in    [LANES];
        logic [DW-1:0]          den_in;
        logic [LANES-1:0]       neg_in;
        logic [WEIGHT_BITS-1:0] max_in;
        logic [NW-1:0]          rem_next [LANES];
        logic [QB-1:0]          q_next   [LANES];

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign neg_in = neg;
            assign max_in = blk_max;
            for (genvar i = 0; i < LANES; i++)
            begin : g_lane
                assign q_in[i] = '0;
            end
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign max_in = max_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // Trial subtraction of the shifted divisor, two bits
        always_comb
        begin
            logic [NW-1:0] r;
            logic [QB-1:0] q;
            logic [NW-1:0] dsh;
            int            b;
            for (int i = 0; i < LANES; i++)
            begin
                r = rem_in[i];
                q = q_in[i];
                for (int j = 0; j < 2; j++)
                begin
                    b = QB - 1 - 2 * k - j;
                    if (b >= 0)
                    begin
                        dsh = NW'(den_in) << b;
                        if (r >= dsh)
                        begin
                            r = r - dsh;
                            q = q | (QB'(1) << b);
                        end
                    end
                end
                rem_next[i] = r;
                q_next[i]   = q;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_in;
                max_reg[k] <= max_in;
            end
        end

        if (k < NDIV - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo     = q_reg[NDIV-1];
    assign quo_neg = neg_reg[NDIV-1];
    assign quo_max = max_reg[NDIV-1];

endmodule
`default_nettype wire

// File: design/bwq_lattice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwq_lattice
// Back end: nearest D8 and D8+1/2 points, squared error of each, choice of
// the closer coset and the final code with clamping and mode selection.
// ----------------------------------------------------------------------------
module bwq_lattice
    import bwq_pkg::*;
#(
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 8,
    localparam int QB = FRACTION_BITS + 3,
    localparam int YW = FRACTION_BITS + 4,
    localparam int XW = FRACTION_BITS + 6,
    localparam int EW = FRACTION_BITS + 2,
    localparam int PW = 2 * FRACTION_BITS + 4,
    localparam int SQ = 2 * FRACTION_BITS + 1,
    localparam int SW = 2 * FRACTION_BITS + 4,
    localparam int CW = ZW + 2
)
(
    input  logic                     clk,
    input  logic [4:0]               en,
    input  cfg_t                     cfg,
    input  logic [QB-1:0]            quo     [LANES],
    input  logic [LANES-1:0]         quo_neg,
    input  logic [WEIGHT_BITS-1:0]   quo_max,
    output logic [WEIGHT_BITS-1:0]   block_max,
    output logic signed [CODE_W-1:0] code    [LANES]
);

    localparam logic signed [XW-1:0] HALF = XW'(1) << (FRACTION_BITS - 1);
    localparam logic [YW-1:0]        HALF_U = YW'(1) << (FRACTION_BITS - 1);

    logic                            int_mode;

    // Stage L1
    logic signed [YW-1:0]            y_next   [LANES];
    logic signed [CODE_W-1:0]        ic_next  [LANES];
    logic signed [ZW-1:0]            z_next   [2][LANES];
    logic [FRACTION_BITS-1:0]        d_next   [2][LANES];
    logic [LANES-1:0]                up_next  [2];
    logic signed [YW-1:0]            y1_reg   [LANES];
    logic signed [CODE_W-1:0]        ic1_reg  [LANES];
    logic signed [ZW-1:0]            z1_reg   [2][LANES];
    logic [FRACTION_BITS-1:0]        d1_reg   [2][LANES];
    logic [LANES-1:0]                up1_reg  [2];
    logic [WEIGHT_BITS-1:0]          max1_reg;

    // Stage L2
    logic signed [ZW-1:0]            zf_next  [2][LANES];
    logic signed [YW-1:0]            y2_reg   [LANES];
    logic signed [CODE_W-1:0]        ic2_reg  [LANES];
    logic signed [ZW-1:0]            z2_reg   [2][LANES];
    logic [WEIGHT_BITS-1:0]          max2_reg;

    // Stage L3
    logic [SQ-1:0]                   sq_next  [2][LANES];
    logic [SQ-1:0]                   sq3_reg  [2][LANES];
    logic signed [CODE_W-1:0]        ic3_reg  [LANES];
    logic signed [ZW-1:0]            z3_reg   [2][LANES];
    logic [WEIGHT_BITS-1:0]          max3_reg;

    // Stage L4
    logic [SW-1:0]                   dist_next [2];
    logic [SW-1:0]                   dist4_reg [2];
    logic signed [CODE_W-1:0]        ic4_reg  [LANES];
    logic signed [ZW-1:0]            z4_reg   [2][LANES];
    logic [WEIGHT_BITS-1:0]          max4_reg;

    // Output stage
    logic signed [CODE_W-1:0]        code_next [LANES];
    logic signed [CODE_W-1:0]        code_reg  [LANES];
    logic [WEIGHT_BITS-1:0]          max5_reg;

    assign int_mode = (cfg.mode == MODE_INT8) || (cfg.mode == MODE_INT4);

    // Signed scaled value, integer code and per-coset rounding
    always_comb
    begin
        logic signed [XW-1:0] s;
        logic [YW-1:0]        ms;
        logic [YW-1:0]        r;
        logic signed [ZW-1:0] z;
        logic signed [XW-1:0] res;
        logic [CODE_W-1:0]    qc;
        for (int i = 0; i < LANES; i++)
        begin
            y_next[i]  = quo_neg[i] ? -$signed(YW'(quo[i])) : $signed(YW'(quo[i]));
            qc         = CODE_W'(quo[i]);
            ic_next[i] = quo_neg[i] ? $signed(-qc) : $signed(qc);
            for (int c = 0; c < 2; c++)
            begin
                s  = XW'(y_next[i]) - ((c == 1) ? HALF : XW'(0));
                ms = s[XW-1] ? YW'(-s) : YW'(s);
                r  = (ms + HALF_U) >> FRACTION_BITS;
                z  = s[XW-1] ? -$signed(ZW'(r)) : $signed(ZW'(r));
                res = s - (XW'(z) <<< FRACTION_BITS);
                d_next[c][i]  = res[XW-1] ? FRACTION_BITS'(-res)
                                          : FRACTION_BITS'(res);
                up_next[c][i] = !res[XW-1] && (res != '0);
                z_next[c][i]  = z;
            end
        end
    end

    // Parity fix on the coordinate farthest from its rounding
    always_comb
    begin
        logic                     par;
        logic [FRACTION_BITS-1:0] best;
        logic [LANE_IDX_W-1:0]    wi;
        for (int c = 0; c < 2; c++)
        begin
            par  = 1'b0;
            best = d1_reg[c][0];
            wi   = '0;
            for (int i = 0; i < LANES; i++)
            begin
                par = par ^ z1_reg[c][i][0];
            end
            for (int i = 1; i < LANES; i++)
            begin
                if (d1_reg[c][i] > best)
                begin
                    best = d1_reg[c][i];
                    wi   = LANE_IDX_W'(i);
                end
            end
            zf_next[c] = z1_reg[c];
            if (par)
            begin
                zf_next[c][wi] = up1_reg[c][wi] ? z1_reg[c][wi] + ZW'(1)
                                                : z1_reg[c][wi] - ZW'(1);
            end
        end
    end

    // Squared error of each coordinate for both cosets
    always_comb
    begin
        logic signed [XW-1:0] diff;
        logic signed [EW-1:0] e;
        logic signed [PW-1:0] p;
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                diff = XW'(y2_reg[i]) - (XW'(z2_reg[c][i]) <<< FRACTION_BITS)
                       - ((c == 1) ? HALF : XW'(0));
                e    = EW'(diff);
                p    = e * e;
                sq_next[c][i] = p[SQ-1:0];
            end
        end
    end

    // Sum the squared errors
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            dist_next[c] = '0;
            for (int i = 0; i < LANES; i++)
            begin
                dist_next[c] = dist_next[c] + SW'(sq3_reg[c][i]);
            end
        end
    end

    // Pick the coset, double, clamp and select by mode
    always_comb
    begin
        logic                 use_half;
        logic signed [CW-1:0] cv;
        logic signed [CW-1:0] lim;
        use_half = dist4_reg[1] < dist4_reg[0];
        lim      = $signed(CW'(cfg.limit));
        for (int i = 0; i < LANES; i++)
        begin
            if (use_half)
            begin
                cv = (CW'(z4_reg[1][i]) <<< 1) + CW'(1);
            end
            else
            begin
                cv = CW'(z4_reg[0][i]) <<< 1;
            end
            if (cv > lim)
            begin
                cv = lim;
            end
            if (cv < -lim)
            begin
                cv = -lim;
            end
            if (max4_reg == '0)
            begin
                code_next[i] = '0;
            end
            else if (int_mode)
            begin
                code_next[i] = ic4_reg[i];
            end
            else
            begin
                code_next[i] = CODE_W'(cv);
            end
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y1_reg   <= y_next;
            ic1_reg  <= ic_next;
            z1_reg   <= z_next;
            d1_reg   <= d_next;
            up1_reg  <= up_next;
            max1_reg <= quo_max;
        end
        if (en[1])
        begin
            y2_reg   <= y1_reg;
            ic2_reg  <= ic1_reg;
            z2_reg   <= zf_next;
            max2_reg <= max1_reg;
        end
        if (en[2])
        begin
            sq3_reg  <= sq_next;
            ic3_reg  <= ic2_reg;
            z3_reg   <= z2_reg;
            max3_reg <= max2_reg;
        end
        if (en[3])
        begin
            dist4_reg <= dist_next;
            ic4_reg   <= ic3_reg;
            z4_reg    <= z3_reg;
            max4_reg  <= max3_reg;
        end
        if (en[4])
        begin
            code_reg <= code_next;
            max5_reg <= max4_reg;
        end
    end

    assign code      = code_reg;
    assign block_max = max5_reg;

endmodule
`default_nettype wire

// File: design/block_weight_quantizer_e8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_weight_quantizer_e8
// Block weight quantiser: block maximum, per-weight scaling by division and
// E8 lattice (D8 or D8+1/2) or per-block INT8 / INT4 codes.
// ----------------------------------------------------------------------------
// Pipeline: the scale, divider and lattice stages in that order; the divider
//   resolves two quotient bits per stage.
// Throughput: one block per cycle unless the output stalls; every stage holds
//   its own valid bit, so empty stages keep filling while the output holds a result.
// Reset: clears all valid bits; mode returns to E8 and the code limit to 15.
// ----------------------------------------------------------------------------
module block_weight_quantizer_e8
    import bwq_pkg::*;
#(
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bwq_weights_if.sink            weights,
    bwq_result_if.source           result
);

    localparam int NW   = WEIGHT_BITS + FRACTION_BITS + 4;
    localparam int DW   = WEIGHT_BITS + 2;
    localparam int QB   = FRACTION_BITS + 3;
    localparam int NDIV = (QB + 1) / 2;
    localparam int NS   = 3 + NDIV + 5;
    localparam logic [WEIGHT_BITS-1:0] MAX_MAG = WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);

    logic [MODE_W-1:0]             mode_reg;
    logic [LIMIT_W-1:0]            limit_reg;
    cfg_t                          cfg;

    logic [NS-1:0]                 v_reg;
    logic [NS-1:0]                 v_next;
    logic [NS-1:0]                 en;

    logic signed [WEIGHT_BITS-1:0] weight [LANES];
    logic [NW-1:0]                 num    [LANES];
    logic [DW-1:0]                 den;
    logic [LANES-1:0]              neg;
    logic [WEIGHT_BITS-1:0]        blk_max;
    logic [QB-1:0]                 quo    [LANES];
    logic [LANES-1:0]              quo_neg;
    logic [WEIGHT_BITS-1:0]        quo_max;
    logic signed [CODE_W-1:0]      code   [LANES];
    logic [WEIGHT_BITS-1:0]        out_max;
    logic                          int4_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUANT_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                REG_E8_LIMIT:   limit_reg <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.limit = limit_reg;

    // Stage enables: a stage advances when empty or when its successor moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || result.ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
        v_next[0] = en[0] ? weights.valid : v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            v_next[s] = en[s] ? v_reg[s-1] : v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign weights.ready = en[0];

    // Unpack the input transfer
    assign weight[0] = weights.weight_0;
    assign weight[1] = weights.weight_1;
    assign weight[2] = weights.weight_2;
    assign weight[3] = weights.weight_3;
    assign weight[4] = weights.weight_4;
    assign weight[5] = weights.weight_5;
    assign weight[6] = weights.weight_6;
    assign weight[7] = weights.weight_7;

    bwq_scale #(
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .clk     (clk),
        .en      (en[2:0]),
        .cfg     (cfg),
        .weight  (weight),
        .num     (num),
        .den     (den),
        .neg     (neg),
        .blk_max (blk_max)
    );

    bwq_div #(
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk     (clk),
        .en      (en[3+NDIV-1:3]),
        .num     (num),
        .den     (den),
        .neg     (neg),
        .blk_max (blk_max),
        .quo     (quo),
        .quo_neg (quo_neg),
        .quo_max (quo_max)
    );

    bwq_lattice #(
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lattice (
        .clk       (clk),
        .en        (en[NS-1:3+NDIV]),
        .cfg       (cfg),
        .quo       (quo),
        .quo_neg   (quo_neg),
        .quo_max   (quo_max),
        .block_max (out_max),
        .code      (code)
    );

    // Drive the output transfer
    assign result.valid     = v_reg[NS-1];
    assign result.block_max = out_max;
    assign result.code_0    = code[0];
    assign result.code_1    = code[1];
    assign result.code_2    = code[2];
    assign result.code_3    = code[3];
    assign result.code_4    = code[4];
    assign result.code_5    = code[5];
    assign result.code_6    = code[6];
    assign result.code_7    = code[7];

    always_comb
    begin
        int4_ok = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            if (code[i] > CODE_W'(INT4_LIM) || code[i] < -CODE_W'(INT4_LIM))
            begin
                int4_ok = 1'b0;
            end
        end
    end

    // Input held off only when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !weights.ready |-> ((&v_reg) && !result.ready))
        else $error("input stalled while the pipeline has room");

    // The block maximum never exceeds the largest possible weight magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.block_max <= MAX_MAG))
        else $error("block maximum out of range");

    // An all-zero block gives all-zero codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.block_max == '0) |->
        (result.code_0 == 0 && result.code_1 == 0 && result.code_2 == 0 &&
         result.code_3 == 0 && result.code_4 == 0 && result.code_5 == 0 &&
         result.code_6 == 0 && result.code_7 == 0))
        else $error("non-zero code for an all-zero block");

    // INT4 codes stay within +-7
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && mode_reg == MODE_INT4) |-> int4_ok)
        else $error("INT4 code outside +-7");

endmodule
`default_nettype wire
